@@ design/j2k_codestream_header_scanner_assert.svh @@
// assertion macros used by the codestream header scanner checker
`ifndef J2K_CODESTREAM_HEADER_SCANNER_ASSERT_SVH
`define J2K_CODESTREAM_HEADER_SCANNER_ASSERT_SVH

// same-cycle implication, held off during reset
`define JCHS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define JCHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/jchs_pkg.sv @@
// types and constants of the codestream header scanner
package jchs_pkg;

    // marker bytes
    localparam logic [7:0] MK_LEAD = 8'hFF;
    localparam logic [7:0] MK_SOC  = 8'h4F;
    localparam logic [7:0] MK_SOD  = 8'h93;
    localparam logic [7:0] MK_EOC  = 8'hD9;
    localparam logic [7:0] MK_SIZ  = 8'h51;
    localparam logic [7:0] MK_COD  = 8'h52;
    localparam logic [7:0] MK_COM  = 8'h64;

    localparam logic [15:0] HEADER_LIMIT_RESET = 16'd600;

    // status codes reported with each result
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_NO_SOC     = 3'd1,
        ERR_NO_SIZ     = 3'd2,
        ERR_TRUNCATED  = 3'd3,
        ERR_BAD_MARKER = 3'd4,
        ERR_NO_COM     = 3'd5,
        ERR_NO_COD     = 3'd6,
        ERR_NO_EOC     = 3'd7
    } err_code_t;

    // parser phases
    typedef enum logic [4:0] {
        PH_SOC  = 5'b00001,
        PH_SIZ  = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_MARK = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic        stream_ok;
        logic [2:0]  error_code;
        logic        lossless;
        logic [15:0] payload_offset;
        logic [31:0] payload_length;
    } out_item_t;

    // parser state handed to the verdict logic on the final byte
    typedef struct packed {
        err_code_t   first_err;
        logic        in_data;
        logic        seen_com;
        logic        seen_cod;
        logic [16:0] next_marker;
        logic [15:0] sod_pos;
        logic [15:0] tail;
        logic [15:0] layers;
    } parse_snap_t;

endpackage

@@ design/jchs_verdict.sv @@
// final status, offset and length decision for one codestream
module jchs_verdict #(
    parameter int POSITION_BITS = 32
) (
    input  logic [POSITION_BITS-1:0] stream_size,
    input  jchs_pkg::parse_snap_t    snap,
    output jchs_pkg::out_item_t      result
);

    localparam int CW = (POSITION_BITS > 19) ? POSITION_BITS + 1 : 20;
    localparam int LW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    logic [CW-1:0]      fs_c;
    logic [LW-1:0]      diff;
    logic               sat;
    jchs_pkg::err_code_t err;
    logic               ok;

    assign fs_c = CW'(stream_size);

    // first failing check decides the code
    always_comb begin
        if (fs_c < CW'(6)) begin
            err = jchs_pkg::ERR_TRUNCATED;
        end else if (snap.first_err == jchs_pkg::ERR_BAD_MARKER &&
                     fs_c < CW'(snap.next_marker) + CW'(4)) begin
            err = jchs_pkg::ERR_TRUNCATED;
        end else if (snap.first_err != jchs_pkg::ERR_NONE) begin
            err = snap.first_err;
        end else if (!snap.in_data) begin
            err = jchs_pkg::ERR_TRUNCATED;
        end else if (fs_c < CW'(snap.sod_pos) + CW'(4)) begin
            err = jchs_pkg::ERR_TRUNCATED;
        end else if (!snap.seen_com) begin
            err = jchs_pkg::ERR_NO_COM;
        end else if (!snap.seen_cod) begin
            err = jchs_pkg::ERR_NO_COD;
        end else if (snap.tail != {jchs_pkg::MK_LEAD, jchs_pkg::MK_EOC}) begin
            err = jchs_pkg::ERR_NO_EOC;
        end else begin
            err = jchs_pkg::ERR_NONE;
        end
    end

    // payload length, saturated to 32 bits
    assign diff = LW'(stream_size) - LW'(snap.sod_pos);
    assign sat  = (diff >> 32) != '0;
    assign ok   = (err == jchs_pkg::ERR_NONE);

    always_comb begin
        result.stream_ok      = ok;
        result.error_code     = err;
        result.lossless       = ok && (snap.layers == 16'd1);
        result.payload_offset = ok ? snap.sod_pos : 16'd0;
        result.payload_length = !ok ? 32'd0 : (sat ? 32'hFFFF_FFFF : diff[31:0]);
    end

endmodule

@@ design/j2k_codestream_header_scanner.sv @@
// top level of the jpeg 2000 codestream header scanner
// Usage:
//   s_valid/s_ready/s_data carry one codestream byte per transaction, with
//   end_of_stream set on the final byte. m_valid/m_ready/m_data carry one
//   status transaction per codestream, produced only for the final byte.
//   cfg_wr_en/cfg_wr_data write header_limit; write it only while idle.
// Timing:
//   one byte per clock sustained while no final byte waits for the output
//   register. Every byte goes through one input register and a single pass
//   of compare and counter logic; the result of the final byte is written
//   into the output register as that byte leaves the input register.
// Stalls:
//   bytes that end no stream keep flowing while a result waits; a final
//   byte waits in the input register until the output register is free,
//   and s_ready drops only then.
// Reset:
//   aresetn (synchronous, active low) empties both registers, clears the
//   parser and sets header_limit to 600. After each final byte the parser
//   returns to its reset state and header_limit is kept.
module j2k_codestream_header_scanner #(
    parameter int POSITION_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  jchs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output jchs_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);

    localparam int P  = POSITION_BITS;
    localparam int CW = (P > 19) ? P + 1 : 20;

    // input register
    logic               in_valid_reg;
    jchs_pkg::in_item_t in_data_reg;
    logic               fire;
    logic               eos;

    // configuration
    logic [15:0] limit_reg;

    // parser state
    logic [P-1:0]        pos_reg,      pos_next;
    jchs_pkg::phase_t    phase_reg,    phase_next;
    logic [16:0]         nmp_reg,      nmp_next;
    logic [7:0]          lhb_reg,      lhb_next;
    logic [16:0]         codpos_reg,   codpos_next;
    logic [15:0]         layers_reg,   layers_next;
    logic                com_reg,      com_next;
    logic                cod_reg,      cod_next;
    logic [15:0]         sod_reg,      sod_next;
    logic [15:0]         tail_reg,     tail_next;
    jchs_pkg::err_code_t err_reg,      err_next;

    // output register
    logic                m_valid_reg;
    jchs_pkg::out_item_t m_data_reg;
    jchs_pkg::out_item_t verdict;
    jchs_pkg::parse_snap_t snap;

    logic [7:0]    b;
    logic          pos_live;
    logic [CW-1:0] pos_c;
    logic [CW-1:0] m_c;
    logic [CW-1:0] cod_c;
    logic [15:0]   seg_len;
    logic [17:0]   nxt;

    assign eos     = in_data_reg.end_of_stream;
    assign fire    = in_valid_reg && (!eos || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign b        = in_data_reg.data_byte;
    assign pos_live = ~&pos_reg;
    assign pos_c    = CW'(pos_reg);
    assign m_c      = CW'(nmp_reg);
    assign cod_c    = CW'(codpos_reg);
    assign seg_len  = {lhb_reg, b};
    assign nxt      = {1'b0, nmp_reg} + 18'd2 + 18'(seg_len);

    // one byte of header parse
    always_comb begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        nmp_next    = nmp_reg;
        lhb_next    = lhb_reg;
        codpos_next = codpos_reg;
        layers_next = layers_reg;
        com_next    = com_reg;
        cod_next    = cod_reg;
        sod_next    = sod_reg;
        err_next    = err_reg;
        tail_next   = {tail_reg[7:0], b};
        if (pos_live) begin
            pos_next = pos_reg + P'(1);
            // layer count bytes of the last cod segment
            if (cod_reg) begin
                if (pos_c == cod_c + CW'(4)) begin
                    layers_next[15:8] = b;
                end else if (pos_c == cod_c + CW'(5)) begin
                    layers_next[7:0] = b;
                end
            end
            if (err_reg == jchs_pkg::ERR_NONE) begin
                unique case (phase_reg)
                    jchs_pkg::PH_SOC: begin
                        if (pos_c == CW'(1)) begin
                            if (tail_next != {jchs_pkg::MK_LEAD, jchs_pkg::MK_SOC}) begin
                                err_next = jchs_pkg::ERR_NO_SOC;
                            end else begin
                                phase_next = jchs_pkg::PH_SIZ;
                            end
                        end
                    end
                    jchs_pkg::PH_SIZ: begin
                        if (pos_c == CW'(3)) begin
                            if (tail_next != {jchs_pkg::MK_LEAD, jchs_pkg::MK_SIZ}) begin
                                err_next = jchs_pkg::ERR_NO_SIZ;
                            end else begin
                                nmp_next   = 17'd2;
                                phase_next = jchs_pkg::PH_LEN;
                            end
                        end
                    end
                    jchs_pkg::PH_LEN: begin
                        if (pos_c == m_c + CW'(2)) begin
                            lhb_next = b;
                        end else if (pos_c == m_c + CW'(3)) begin
                            if (seg_len < 16'd2) begin
                                err_next = jchs_pkg::ERR_BAD_MARKER;
                            end else if ({1'b0, nxt} + 19'd2 > 19'(limit_reg)) begin
                                err_next = jchs_pkg::ERR_TRUNCATED;
                            end else begin
                                nmp_next   = nxt[16:0];
                                phase_next = jchs_pkg::PH_MARK;
                            end
                        end
                    end
                    jchs_pkg::PH_MARK: begin
                        if (pos_c == m_c + CW'(1)) begin
                            if (tail_next[15:8] != jchs_pkg::MK_LEAD) begin
                                err_next = jchs_pkg::ERR_BAD_MARKER;
                            end else begin
                                if (tail_next[7:0] == jchs_pkg::MK_COM) begin
                                    com_next = 1'b1;
                                end
                                if (tail_next[7:0] == jchs_pkg::MK_COD) begin
                                    cod_next    = 1'b1;
                                    codpos_next = nmp_reg + 17'd2;
                                end
                                if (tail_next[7:0] == jchs_pkg::MK_SOD) begin
                                    sod_next   = nmp_reg[15:0];
                                    phase_next = jchs_pkg::PH_DATA;
                                end else begin
                                    phase_next = jchs_pkg::PH_LEN;
                                end
                            end
                        end
                    end
                    jchs_pkg::PH_DATA: begin
                        phase_next = jchs_pkg::PH_DATA;
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // parser state as seen after the final byte
    always_comb begin
        snap.first_err   = err_next;
        snap.in_data     = (phase_next == jchs_pkg::PH_DATA);
        snap.seen_com    = com_next;
        snap.seen_cod    = cod_next;
        snap.next_marker = nmp_next;
        snap.sod_pos     = sod_next;
        snap.tail        = tail_next;
        snap.layers      = layers_next;
    end

    jchs_verdict #(
        .POSITION_BITS (P)
    ) u_verdict (
        .stream_size (pos_next),
        .snap        (snap),
        .result      (verdict)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= jchs_pkg::HEADER_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // parser state, cleared after each final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && eos)) begin
            pos_reg    <= '0;
            phase_reg  <= jchs_pkg::PH_SOC;
            nmp_reg    <= '0;
            lhb_reg    <= '0;
            codpos_reg <= '0;
            layers_reg <= '0;
            com_reg    <= 1'b0;
            cod_reg    <= 1'b0;
            sod_reg    <= '0;
            tail_reg   <= '0;
            err_reg    <= jchs_pkg::ERR_NONE;
        end else if (fire) begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            nmp_reg    <= nmp_next;
            lhb_reg    <= lhb_next;
            codpos_reg <= codpos_next;
            layers_reg <= layers_next;
            com_reg    <= com_next;
            cod_reg    <= cod_next;
            sod_reg    <= sod_next;
            tail_reg   <= tail_next;
            err_reg    <= err_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && eos) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (fire && eos) begin
            m_data_reg <= verdict;
        end
    end

endmodule

@@ design/jchs_checker.sv @@
// port checker for the codestream header scanner, bound to the top level
`include "j2k_codestream_header_scanner_assert.svh"

module jchs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input jchs_pkg::out_item_t m_data
);

    // a stalled result transaction holds
    `JCHS_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // ok flag agrees with the status code
    `JCHS_ASSERT_IMPL(a_ok_code, m_valid, m_data.stream_ok == (m_data.error_code == jchs_pkg::ERR_NONE), "ok flag and status code disagree")

    // a failed stream reports no payload
    `JCHS_ASSERT_IMPL(a_fail_zero, m_valid && !m_data.stream_ok, !m_data.lossless && m_data.payload_offset == 16'd0 && m_data.payload_length == 32'd0, "failed stream reports payload")

    // a good stream holds at least the sod marker and the eoc marker
    `JCHS_ASSERT_IMPL(a_ok_length, m_valid && m_data.stream_ok, m_data.payload_length >= 32'd4 && m_data.payload_offset >= 16'd6, "good stream with short payload")

endmodule

bind j2k_codestream_header_scanner jchs_checker u_jchs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
